[rtl/lvt_pkg.sv]
package lvt_pkg;

   localparam int DIST_W       = 20;
   localparam int ID_W         = 6;
   localparam int GAP_W        = DIST_W + 3;
   localparam int MAX_CARS     = 64;
   localparam int POS_BITS_DEF = 24;
   localparam int CSR_IDX_W    = 2;

   localparam logic [DIST_W-1:0] THRESHOLD_RESET = DIST_W'(800);
   localparam logic [DIST_W-1:0] LENGTH_RESET    = DIST_W'(48000);
   localparam logic [ID_W-1:0]   OWN_ID_RESET    = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIST_THRESHOLD = 2'd0,
      CSR_TRACK_LENGTH   = 2'd1,
      CSR_OWN_CAR_ID     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIST_W-1:0] dist_threshold;
      logic [DIST_W-1:0] track_length;
      logic [ID_W-1:0]   own_car_id;
   } lvt_cfg_type;

   // scored record handed from the scoring stage to the tracker
   typedef struct packed {
      logic            valid;
      logic            last;
      logic            in_range;
      logic            gap_ok;
      logic            cand;
      logic [ID_W-1:0] id;
   } lvt_ctl_type;

endpackage

[rtl/lead_vehicle_tracker_core.sv]
// A frame's result is registered after its last record passes the input register, the
// scored register (distance/square stage) and the tracker update into the result register.
// Throughput: one car record per cycle; the tracker update is a single registered step.
// A waiting result holds a frame-end record in the tracker stage; the input backs up behind it.
// Reset: synchronous, active high; clears leader and frame state, loads register defaults.
module lead_vehicle_tracker_core #(
   parameter  int POS_BITS = lvt_pkg::POS_BITS_DEF,
   localparam int REQ_BITS = 2 * lvt_pkg::DIST_W + lvt_pkg::ID_W + 4 * POS_BITS,
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = 3 + lvt_pkg::ID_W + 4 * POS_BITS,
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // own_track_dist, own_x, own_y, car_id, car_track_dist, car_x, car_y
   input  logic [REQ_W-1:0]              req_tdata,
   // last_of_frame
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // following, leader_id, lead_x, lead_y, prev_lead_x, prev_lead_y,
   // speed_tracked, lost_leader
   output logic [RSP_W-1:0]              rsp_tdata,
   input  logic                          csr_we,
   input  logic [lvt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lvt_pkg::DIST_W-1:0]    csr_wdata
);
   import lvt_pkg::*;

   localparam int OFF_OWN_X  = DIST_W;
   localparam int OFF_OWN_Y  = OFF_OWN_X + POS_BITS;
   localparam int OFF_ID     = OFF_OWN_Y + POS_BITS;
   localparam int OFF_CAR_D  = OFF_ID + ID_W;
   localparam int OFF_CAR_X  = OFF_CAR_D + DIST_W;
   localparam int OFF_CAR_Y  = OFF_CAR_X + POS_BITS;

   lvt_cfg_type                cfg;
   lvt_ctl_type                ctl;
   logic                       take;
   logic [DIST_W-1:0]          own_track_dist, car_track_dist;
   logic signed [POS_BITS-1:0] own_x, own_y, car_x, car_y;
   logic [ID_W-1:0]            car_id;
   logic signed [POS_BITS-1:0] cx, cy;
   logic [2*POS_BITS-1:0]      sq_x, sq_y;
   logic                       following, speed_tracked, lost_leader;
   logic [ID_W-1:0]            leader_id;
   logic signed [POS_BITS-1:0] lead_x, lead_y, prev_lead_x, prev_lead_y;

   assign own_track_dist = req_tdata[DIST_W-1:0];
   assign own_x          = req_tdata[OFF_OWN_X +: POS_BITS];
   assign own_y          = req_tdata[OFF_OWN_Y +: POS_BITS];
   assign car_id         = req_tdata[OFF_ID +: ID_W];
   assign car_track_dist = req_tdata[OFF_CAR_D +: DIST_W];
   assign car_x          = req_tdata[OFF_CAR_X +: POS_BITS];
   assign car_y          = req_tdata[OFF_CAR_Y +: POS_BITS];

   lvt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lvt_score #(.POS_BITS(POS_BITS)) u_score (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .own_track_dist (own_track_dist),
      .own_x          (own_x),
      .own_y          (own_y),
      .car_id         (car_id),
      .car_track_dist (car_track_dist),
      .car_x          (car_x),
      .car_y          (car_y),
      .last_of_frame  (req_tlast),
      .take           (take),
      .ctl            (ctl),
      .cx             (cx),
      .cy             (cy),
      .sq_x           (sq_x),
      .sq_y           (sq_y)
   );

   lvt_track #(.POS_BITS(POS_BITS)) u_track (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .cx            (cx),
      .cy            (cy),
      .sq_x          (sq_x),
      .sq_y          (sq_y),
      .take          (take),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .following     (following),
      .leader_id     (leader_id),
      .lead_x        (lead_x),
      .lead_y        (lead_y),
      .prev_lead_x   (prev_lead_x),
      .prev_lead_y   (prev_lead_y),
      .speed_tracked (speed_tracked),
      .lost_leader   (lost_leader)
   );

   assign rsp_tdata = RSP_W'({lost_leader, speed_tracked, prev_lead_y, prev_lead_x,
                              lead_y, lead_x, leader_id, following});

endmodule

[rtl/lvt_csr.sv]
module lvt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lvt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lvt_pkg::DIST_W-1:0]          csr_wdata,
   output lvt_pkg::lvt_cfg_type                cfg
);
   import lvt_pkg::*;

   lvt_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DIST_THRESHOLD: cfg_in.dist_threshold = csr_wdata;
            CSR_TRACK_LENGTH:   cfg_in.track_length   = csr_wdata;
            CSR_OWN_CAR_ID:     cfg_in.own_car_id     = csr_wdata[ID_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dist_threshold <= THRESHOLD_RESET;
         cfg_ff.track_length   <= LENGTH_RESET;
         cfg_ff.own_car_id     <= OWN_ID_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/lvt_score.sv]
module lvt_score #(
   parameter int POS_BITS = lvt_pkg::POS_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lvt_pkg::lvt_cfg_type              cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lvt_pkg::DIST_W-1:0]        own_track_dist,
   input  logic signed [POS_BITS-1:0]        own_x,
   input  logic signed [POS_BITS-1:0]        own_y,
   input  logic [lvt_pkg::ID_W-1:0]          car_id,
   input  logic [lvt_pkg::DIST_W-1:0]        car_track_dist,
   input  logic signed [POS_BITS-1:0]        car_x,
   input  logic signed [POS_BITS-1:0]        car_y,
   input  logic                              last_of_frame,
   input  logic                              take,
   output lvt_pkg::lvt_ctl_type              ctl,
   output logic signed [POS_BITS-1:0]        cx,
   output logic signed [POS_BITS-1:0]        cy,
   output logic [2*POS_BITS-1:0]             sq_x,
   output logic [2*POS_BITS-1:0]             sq_y
);
   import lvt_pkg::*;

   // input register
   logic                       s1_valid_ff, s1_valid_in;
   logic [DIST_W-1:0]          s1_own_d_ff, s1_car_d_ff;
   logic signed [POS_BITS-1:0] s1_own_x_ff, s1_own_y_ff, s1_car_x_ff, s1_car_y_ff;
   logic [ID_W-1:0]            s1_id_ff;
   logic                       s1_last_ff;

   // scored register
   lvt_ctl_type                s2_ctl_ff, s2_ctl_in;
   logic signed [POS_BITS-1:0] s2_cx_ff, s2_cy_ff;
   logic [2*POS_BITS-1:0]      s2_sqx_ff, s2_sqy_ff, s2_sqx_in, s2_sqy_in;

   logic                       ld2;
   logic                       req_xfer;
   logic signed [GAP_W-1:0]    own_d_s, car_d_s, thr_s, len_s, lim_s, gap_s;
   logic                       wrap, gap_ok, in_range;
   logic signed [POS_BITS:0]   dxs, dys;
   logic [POS_BITS:0]          dx_mag, dy_mag;
   logic [POS_BITS-1:0]        dx, dy;

   assign ld2       = s1_valid_ff && (!s2_ctl_ff.valid || take);
   assign req_ready = !s1_valid_ff || ld2;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (ld2) begin
         s1_valid_in = 1'b0;
      end
   end

   // along-track gap, wrapped by one lap near the start line
   always_comb begin
      own_d_s = signed'({{(GAP_W-DIST_W){1'b0}}, s1_own_d_ff});
      car_d_s = signed'({{(GAP_W-DIST_W){1'b0}}, s1_car_d_ff});
      thr_s   = signed'({{(GAP_W-DIST_W){1'b0}}, cfg.dist_threshold});
      len_s   = signed'({{(GAP_W-DIST_W){1'b0}}, cfg.track_length});
      lim_s   = len_s - thr_s;
      wrap    = (s1_car_d_ff < cfg.dist_threshold) && (own_d_s > lim_s);
      gap_s   = wrap ? (car_d_s + len_s - own_d_s) : (car_d_s - own_d_s);
      gap_ok  = (gap_s > 0) && (gap_s <= thr_s);
   end

   assign in_range = (int'(s1_id_ff) < MAX_CARS);

   always_comb begin
      dxs    = {s1_car_x_ff[POS_BITS-1], s1_car_x_ff} - {s1_own_x_ff[POS_BITS-1], s1_own_x_ff};
      dys    = {s1_car_y_ff[POS_BITS-1], s1_car_y_ff} - {s1_own_y_ff[POS_BITS-1], s1_own_y_ff};
      dx_mag = dxs[POS_BITS] ? unsigned'(-dxs) : unsigned'(dxs);
      dy_mag = dys[POS_BITS] ? unsigned'(-dys) : unsigned'(dys);
      dx     = dx_mag[POS_BITS-1:0];
      dy     = dy_mag[POS_BITS-1:0];
      s2_sqx_in = dx * dx;
      s2_sqy_in = dy * dy;
   end

   always_comb begin
      s2_ctl_in = s2_ctl_ff;
      if (ld2) begin
         s2_ctl_in.valid    = 1'b1;
         s2_ctl_in.last     = s1_last_ff;
         s2_ctl_in.in_range = in_range;
         s2_ctl_in.gap_ok   = gap_ok;
         s2_ctl_in.cand     = in_range && gap_ok && (s1_id_ff != cfg.own_car_id);
         s2_ctl_in.id       = s1_id_ff;
      end else if (take) begin
         s2_ctl_in.valid    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_ctl_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_ctl_ff   <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_own_d_ff <= own_track_dist;
         s1_own_x_ff <= own_x;
         s1_own_y_ff <= own_y;
         s1_id_ff    <= car_id;
         s1_car_d_ff <= car_track_dist;
         s1_car_x_ff <= car_x;
         s1_car_y_ff <= car_y;
         s1_last_ff  <= last_of_frame;
      end
      if (ld2) begin
         s2_cx_ff  <= s1_car_x_ff;
         s2_cy_ff  <= s1_car_y_ff;
         s2_sqx_ff <= s2_sqx_in;
         s2_sqy_ff <= s2_sqy_in;
      end
   end

   assign ctl  = s2_ctl_ff;
   assign cx   = s2_cx_ff;
   assign cy   = s2_cy_ff;
   assign sq_x = s2_sqx_ff;
   assign sq_y = s2_sqy_ff;

endmodule

[rtl/lvt_track.sv]
module lvt_track #(
   parameter int POS_BITS = lvt_pkg::POS_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lvt_pkg::lvt_ctl_type              ctl,
   input  logic signed [POS_BITS-1:0]        cx,
   input  logic signed [POS_BITS-1:0]        cy,
   input  logic [2*POS_BITS-1:0]             sq_x,
   input  logic [2*POS_BITS-1:0]             sq_y,
   output logic                              take,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              following,
   output logic [lvt_pkg::ID_W-1:0]          leader_id,
   output logic signed [POS_BITS-1:0]        lead_x,
   output logic signed [POS_BITS-1:0]        lead_y,
   output logic signed [POS_BITS-1:0]        prev_lead_x,
   output logic signed [POS_BITS-1:0]        prev_lead_y,
   output logic                              speed_tracked,
   output logic                              lost_leader
);
   import lvt_pkg::*;

   localparam int SUM_W = 2 * POS_BITS + 1;
   localparam int QW    = (SUM_W > 64) ? 64 : SUM_W;

   // leader state
   logic                       following_ff, following_in;
   logic [ID_W-1:0]            leader_ff, leader_in;
   logic signed [POS_BITS-1:0] cur_x_ff, cur_y_ff, old_x_ff, old_y_ff;
   logic signed [POS_BITS-1:0] cur_x_in, cur_y_in, old_x_in, old_y_in;
   logic                       tracked_ff, tracked_in;

   // per-frame state
   logic                       fl_ok_ff, fl_ok_in;
   logic signed [POS_BITS-1:0] fl_x_ff, fl_y_ff, fl_x_in, fl_y_in;
   logic                       best_found_ff, best_found_in;
   logic [ID_W-1:0]            best_id_ff, best_id_in;
   logic [QW-1:0]              best_sq_ff, best_sq_in;
   logic signed [POS_BITS-1:0] best_x_ff, best_y_ff, best_x_in, best_y_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       o_follow_ff, o_follow_in, o_tracked_ff, o_tracked_in;
   logic                       o_lost_ff, o_lost_in;
   logic [ID_W-1:0]            o_id_ff, o_id_in;
   logic signed [POS_BITS-1:0] o_x_ff, o_y_ff, o_px_ff, o_py_ff;
   logic signed [POS_BITS-1:0] o_x_in, o_y_in, o_px_in, o_py_in;

   logic [SUM_W-1:0]           sq_sum;
   logic [QW-1:0]              sq_val;
   logic                       out_free, lead_hit, upd_best;
   logic                       fl_ok_upd, best_found_upd;
   logic signed [POS_BITS-1:0] fl_x_upd, fl_y_upd, best_x_upd, best_y_upd;
   logic [ID_W-1:0]            best_id_upd;
   logic [QW-1:0]              best_sq_upd;

   assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};

   generate
      if (SUM_W > QW) begin : g_sat
         assign sq_val = (|sq_sum[SUM_W-1:QW]) ? '1 : sq_sum[QW-1:0];
      end else begin : g_nosat
         assign sq_val = sq_sum;
      end
   endgenerate

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take     = ctl.valid && (!ctl.last || out_free);
   assign lead_hit = ctl.in_range && following_ff && (ctl.id == leader_ff);
   assign upd_best = ctl.cand && (!best_found_ff || (sq_val < best_sq_ff));

   always_comb begin
      // frame state including the record in hand
      fl_ok_upd      = lead_hit ? ctl.gap_ok : fl_ok_ff;
      fl_x_upd       = lead_hit ? cx : fl_x_ff;
      fl_y_upd       = lead_hit ? cy : fl_y_ff;
      best_found_upd = best_found_ff || upd_best;
      best_id_upd    = upd_best ? ctl.id : best_id_ff;
      best_sq_upd    = upd_best ? sq_val : best_sq_ff;
      best_x_upd     = upd_best ? cx : best_x_ff;
      best_y_upd     = upd_best ? cy : best_y_ff;

      following_in  = following_ff;
      leader_in     = leader_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      old_x_in      = old_x_ff;
      old_y_in      = old_y_ff;
      tracked_in    = tracked_ff;
      fl_ok_in      = fl_ok_ff;
      fl_x_in       = fl_x_ff;
      fl_y_in       = fl_y_ff;
      best_found_in = best_found_ff;
      best_id_in    = best_id_ff;
      best_sq_in    = best_sq_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      o_lost_in     = o_lost_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (take) begin
         if (!ctl.last) begin
            fl_ok_in      = fl_ok_upd;
            fl_x_in       = fl_x_upd;
            fl_y_in       = fl_y_upd;
            best_found_in = best_found_upd;
            best_id_in    = best_id_upd;
            best_sq_in    = best_sq_upd;
            best_x_in     = best_x_upd;
            best_y_in     = best_y_upd;
         end else begin
            if (following_ff && fl_ok_upd) begin
               // keep the leader, shift current to previous
               old_x_in   = cur_x_ff;
               old_y_in   = cur_y_ff;
               cur_x_in   = fl_x_upd;
               cur_y_in   = fl_y_upd;
               tracked_in = 1'b1;
               o_lost_in  = 1'b0;
            end else begin
               // drop the leader and take the nearest candidate, if any
               o_lost_in     = following_ff;
               following_in  = best_found_upd;
               leader_in     = best_found_upd ? best_id_upd : '0;
               cur_x_in      = best_found_upd ? best_x_upd : '0;
               cur_y_in      = best_found_upd ? best_y_upd : '0;
               old_x_in      = '0;
               old_y_in      = '0;
               tracked_in    = 1'b0;
            end
            fl_ok_in      = 1'b0;
            fl_x_in       = '0;
            fl_y_in       = '0;
            best_found_in = 1'b0;
            best_id_in    = '0;
            best_sq_in    = '1;
            best_x_in     = '0;
            best_y_in     = '0;
            rsp_valid_in  = 1'b1;
         end
      end

      o_follow_in  = following_in;
      o_id_in      = leader_in;
      o_x_in       = cur_x_in;
      o_y_in       = cur_y_in;
      o_px_in      = old_x_in;
      o_py_in      = old_y_in;
      o_tracked_in = tracked_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         following_ff  <= 1'b0;
         leader_ff     <= '0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         old_x_ff      <= '0;
         old_y_ff      <= '0;
         tracked_ff    <= 1'b0;
         fl_ok_ff      <= 1'b0;
         fl_x_ff       <= '0;
         fl_y_ff       <= '0;
         best_found_ff <= 1'b0;
         best_id_ff    <= '0;
         best_sq_ff    <= '1;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         following_ff  <= following_in;
         leader_ff     <= leader_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         old_x_ff      <= old_x_in;
         old_y_ff      <= old_y_in;
         tracked_ff    <= tracked_in;
         fl_ok_ff      <= fl_ok_in;
         fl_x_ff       <= fl_x_in;
         fl_y_ff       <= fl_y_in;
         best_found_ff <= best_found_in;
         best_id_ff    <= best_id_in;
         best_sq_ff    <= best_sq_in;
         best_x_ff     <= best_x_in;
         best_y_ff     <= best_y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, loaded on the frame-end transfer only
   always_ff @(posedge clock) begin
      if (take && ctl.last) begin
         o_follow_ff  <= o_follow_in;
         o_id_ff      <= o_id_in;
         o_x_ff       <= o_x_in;
         o_y_ff       <= o_y_in;
         o_px_ff      <= o_px_in;
         o_py_ff      <= o_py_in;
         o_tracked_ff <= o_tracked_in;
         o_lost_ff    <= o_lost_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign following     = o_follow_ff;
   assign leader_id     = o_id_ff;
   assign lead_x        = o_x_ff;
   assign lead_y        = o_y_ff;
   assign prev_lead_x   = o_px_ff;
   assign prev_lead_y   = o_py_ff;
   assign speed_tracked = o_tracked_ff;
   assign lost_leader   = o_lost_ff;

endmodule
